[design/source_tokenizer_unit_macros.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define STOK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define STOK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define STOK_ASSERT(lbl, clk, rst, prop, msg)
`define STOK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[design/stok_pkg.sv]
`default_nettype none

package stok_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] code_byte;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  token_length;
    logic        last_of_run;
  } out_t;

  // up to two tokens produced per source word
  typedef struct packed {
    logic [1:0] cnt;
    out_t       tok0;
    out_t       tok1;
  } push_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COLON,
    MODE_UTF8
  } scan_mode_t;

  typedef enum logic [5:0] {
    KIND_EOF, KIND_IDENT, KIND_NUMBER,
    KIND_FN, KIND_RETURN, KIND_INT, KIND_CHAR, KIND_MODULE, KIND_USE,
    KIND_UTF8,
    KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_LPAREN, KIND_RPAREN,
    KIND_COMMA, KIND_SEMI, KIND_COLON, KIND_DCOLON, KIND_DOT, KIND_LBRACK,
    KIND_RBRACK, KIND_LBRACE, KIND_RBRACE, KIND_LT, KIND_GT, KIND_PERCENT,
    KIND_BSLASH, KIND_SQUOTE, KIND_DQUOTE, KIND_QUEST, KIND_PIPE, KIND_AMP,
    KIND_EQ, KIND_UNKNOWN
  } token_kind_t;

  localparam int NUM_KW = 6;
  localparam logic [47:0] KW_VALUE [NUM_KW] = '{
    48'h666E, 48'h72657475726E, 48'h696E74,
    48'h63686172, 48'h6D6F64756C65, 48'h757365
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd6, 4'd3, 4'd4, 4'd6, 4'd3
  };

  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4    = 8'hF0;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // single-byte punctuation; everything not listed is unknown
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    token_kind_t k;
    case (b)
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h2F: k = KIND_SLASH;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h2C: k = KIND_COMMA;
      8'h3B: k = KIND_SEMI;
      8'h2E: k = KIND_DOT;
      8'h5B: k = KIND_LBRACK;
      8'h5D: k = KIND_RBRACK;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      8'h3C: k = KIND_LT;
      8'h3E: k = KIND_GT;
      8'h25: k = KIND_PERCENT;
      8'h5C: k = KIND_BSLASH;
      8'h27: k = KIND_SQUOTE;
      8'h22: k = KIND_DQUOTE;
      8'h3F: k = KIND_QUEST;
      8'h7C: k = KIND_PIPE;
      8'h26: k = KIND_AMP;
      8'h3D: k = KIND_EQ;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic out_t make_tok(input logic [5:0] kind, input logic [15:0] line,
                                    input logic [15:0] col, input logic [7:0] len,
                                    input logic last);
    out_t t;
    t.token_kind   = kind;
    t.token_line   = line;
    t.token_column = col;
    t.token_length = len;
    t.last_of_run  = last;
    return t;
  endfunction

endpackage

`default_nettype wire

[design/stok_scan.sv]
`default_nettype none
`include "source_tokenizer_unit_macros.svh"

module stok_scan import stok_pkg::*; #(
  parameter int KEYWORD_CHARS = 6
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  in_t   word,
  output logic  busy,
  output push_t push
);

  localparam int WIN_W = 8 * KEYWORD_CHARS;

  // input register
  logic s1_valid;
  in_t  s1_word;

  // scan state
  scan_mode_t       mode, mode_next;
  logic [1:0]       left, left_next;
  logic [WIN_W-1:0] window, window_next;
  logic [7:0]       plen, plen_next;
  logic [15:0]      cur_line, line_next;
  logic [15:0]      cur_col, col_next;
  logic [15:0]      st_line, st_line_next;
  logic [15:0]      st_col, st_col_next;

  logic [7:0] b;
  logic [7:0] grown;
  logic [1:0] left_dec;
  logic       flush, start, dcolon, eof, emit, adv;
  logic       a_v, b_v;
  logic [5:0] flush_kind, ident_kind, emit_kind;
  logic [7:0] flush_len;
  out_t       tok_a, tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_word <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      left     <= '0;
      window   <= '0;
      plen     <= '0;
      cur_line <= 16'd1;
      cur_col  <= 16'd1;
      st_line  <= 16'd1;
      st_col   <= 16'd1;
    end else begin
      mode     <= mode_next;
      left     <= left_next;
      window   <= window_next;
      plen     <= plen_next;
      cur_line <= line_next;
      cur_col  <= col_next;
      st_line  <= st_line_next;
      st_col   <= st_col_next;
    end
  end

  // keyword match: length must agree and the keyword must fit the window
  always_comb begin
    logic [63:0] wext;
    logic [63:0] mask;
    logic        hit;
    wext       = 64'(window);
    hit        = 1'b0;
    ident_kind = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      mask = (64'd1 << (8 * int'(KW_LEN[i]))) - 64'd1;
      if (!hit && int'(KW_LEN[i]) <= KEYWORD_CHARS && plen == 8'(KW_LEN[i]) &&
          (wext & mask) == 64'(KW_VALUE[i])) begin
        hit        = 1'b1;
        ident_kind = 6'(KIND_FN) + 6'(i);
      end
    end
  end

  always_comb begin
    b            = s1_word.code_byte;
    mode_next    = mode;
    left_next    = left;
    window_next  = window;
    plen_next    = plen;
    line_next    = cur_line;
    col_next     = cur_col;
    st_line_next = st_line;
    st_col_next  = st_col;
    flush        = 1'b0;
    start        = 1'b0;
    dcolon       = 1'b0;
    eof          = 1'b0;
    emit         = 1'b0;
    adv          = 1'b0;
    grown        = sat_inc8(plen);
    left_dec     = (left != 2'd0) ? left - 2'd1 : 2'd0;

    if (s1_valid) begin
      if (s1_word.command) begin
        flush = 1'b1;
        eof   = 1'b1;
      end else begin
        case (mode)
          MODE_UTF8: begin
            // continuation bytes taken blindly, no position change
            plen_next = grown;
            left_next = left_dec;
            if (left_dec == 2'd0) flush = 1'b1;
          end
          MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b) || b == CH_UNDERSCORE) begin
              window_next = WIN_W'({window, b});
              plen_next   = grown;
              adv         = 1'b1;
            end else begin
              flush = 1'b1;
              start = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(b)) begin
              plen_next = grown;
              adv       = 1'b1;
            end else begin
              flush = 1'b1;
              start = 1'b1;
            end
          end
          MODE_COLON: begin
            if (b == CH_COLON) begin
              dcolon    = 1'b1;
              adv       = 1'b1;
              mode_next = MODE_IDLE;
              plen_next = '0;
            end else begin
              flush = 1'b1;
              start = 1'b1;
            end
          end
          default: start = 1'b1;
        endcase
      end

      if (flush) begin
        mode_next = MODE_IDLE;
        left_next = '0;
        plen_next = '0;
      end

      if (start) begin
        mode_next = MODE_IDLE;
        adv       = 1'b1;
        if (!is_space(b)) begin
          st_line_next = cur_line;
          st_col_next  = cur_col;
          plen_next    = 8'd1;
          if (b >= UTF8_LEAD2) begin
            mode_next = MODE_UTF8;
            left_next = (b >= UTF8_LEAD4) ? 2'd3 : (b >= UTF8_LEAD3) ? 2'd2 : 2'd1;
            adv       = 1'b1;
          end else if (is_alpha(b) || b == CH_UNDERSCORE) begin
            mode_next   = MODE_IDENT;
            window_next = WIN_W'(b);
          end else if (is_digit(b)) begin
            mode_next = MODE_NUMBER;
          end else if (b == CH_COLON) begin
            mode_next = MODE_COLON;
          end else begin
            plen_next = '0;
            emit      = 1'b1;
          end
        end
      end

      if (adv) begin
        if (b == CH_LF) begin
          line_next = sat_inc16(cur_line);
          col_next  = 16'd1;
        end else begin
          col_next = sat_inc16(cur_col);
        end
      end
    end
  end

  always_comb begin
    case (mode)
      MODE_IDENT:  flush_kind = ident_kind;
      MODE_NUMBER: flush_kind = KIND_NUMBER;
      MODE_COLON:  flush_kind = KIND_COLON;
      MODE_UTF8:   flush_kind = KIND_UTF8;
      default:     flush_kind = KIND_EOF;
    endcase
    case (mode)
      MODE_COLON: flush_len = 8'd1;
      // partial character at end of source keeps the bytes seen so far
      MODE_UTF8:  flush_len = eof ? plen : grown;
      default:    flush_len = plen;
    endcase
  end

  assign emit_kind = punct_kind(b);

  // slot A: pending token or '::'; slot B: fresh punctuation or eof
  assign a_v = (flush && mode != MODE_IDLE) || dcolon;
  assign b_v = eof || emit;

  always_comb begin
    if (dcolon) begin
      tok_a = make_tok(KIND_DCOLON, st_line, st_col, 8'd2, 1'b0);
    end else begin
      tok_a = make_tok(flush_kind, st_line, st_col, flush_len, 1'b0);
    end
    if (eof) begin
      tok_b = make_tok(KIND_EOF, cur_line, cur_col, 8'd0, 1'b1);
    end else begin
      tok_b = make_tok(emit_kind, cur_line, cur_col, 8'd1, 1'b1);
    end
    push.cnt  = 2'(a_v) + 2'(b_v);
    push.tok1 = tok_b;
    if (a_v) begin
      push.tok0             = tok_a;
      push.tok0.last_of_run = !b_v;
    end else begin
      push.tok0 = tok_b;
    end
  end

  assign busy = s1_valid;

  `STOK_ASSERT(a_utf8_left, clk, rst, (mode == MODE_UTF8) == (left != 2'd0), "utf8 count out of step with mode")
  `STOK_ASSERT(a_pend_len, clk, rst, (mode == MODE_IDLE) || (plen != 8'd0), "open token with zero length")
  `STOK_ASSERT_NEXT(a_cmd_idle, clk, rst, s1_valid && s1_word.command, mode == MODE_IDLE && plen == 8'd0, "end of source left a token open")

endmodule

`default_nettype wire

[design/stok_queue.sv]
`default_nettype none
`include "source_tokenizer_unit_macros.svh"

module stok_queue import stok_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  output logic            valid,
  input  logic            stall,
  output out_t            word,
  output logic [Q_CW-1:0] count
);

  out_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic            pop;

  assign valid = count != '0;
  assign word  = mem[rd_ptr];
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.cnt);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count + Q_CW'(push.cnt) - Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + Q_AW'(1)] <= push.tok1;
    end
  end

  `STOK_ASSERT(a_q_bound, clk, rst, 32'(count) <= Q_DEPTH, "queue count above depth")
  `STOK_ASSERT(a_q_room, clk, rst, 32'(count) + 32'(push.cnt) <= Q_DEPTH + 32'(pop), "queue overflow on push")

endmodule

`default_nettype wire

[design/source_tokenizer_unit.sv]
// Flow: a source word accepted on take is held in the input register and scanned there;
//   its tokens are then written to the token queue, which drives tok_valid.
// Throughput: one source word per cycle while the token queue drains; a word that
//   yields two tokens sends them out singly, and the 8-entry queue absorbs the burst.
// Reset: scanner idle, position line 1 column 1, token queue empty.
`default_nettype none

module source_tokenizer_unit import stok_pkg::*; #(
  parameter int KEYWORD_CHARS = 6
) (
  input  logic clk,
  input  logic rst,
  // source words
  input  logic src_valid,
  output logic src_stall,
  input  in_t  src_word,
  // token words
  output logic tok_valid,
  input  logic tok_stall,
  output out_t tok_word
);

  logic            take;
  logic            busy;
  push_t           push;
  logic [Q_CW-1:0] q_count;

  assign take = src_valid && !src_stall;

  // Room check from registers only: a word in the input register may still
  // push two tokens, and the word taken now may push two more next cycle.
  assign src_stall = (5'(q_count) + (busy ? 5'd2 : 5'd0)) > 5'(Q_DEPTH - 2);

  // Scanner: input register, tokenizer state and the token builder.
  stok_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .take(take),
    .word(src_word),
    .busy(busy),
    .push(push)
  );

  // Result queue: takes up to two tokens a cycle, hands out one while tok_stall is low.
  stok_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .valid(tok_valid),
    .stall(tok_stall),
    .word (tok_word),
    .count(q_count)
  );

endmodule

`default_nettype wire
